// ----- rtl/hvn_pkg.sv -----
// ----------------------------------------------------------------------------
// hvn_pkg
// Types, codes and constants shared by the height-field vertex normal unit.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int unsigned MAX_COLS_DEF = 256;
  localparam int unsigned MAX_ROWS_DEF = 256;

  localparam int unsigned NORM_STEPS = 16;
  localparam int unsigned SAMPLES    = 8;

  localparam int unsigned SUM_W  = 11;
  localparam int unsigned SY_W   = 10;
  localparam int unsigned SQ_W   = 20;
  localparam int unsigned LEN_W  = 22;
  localparam int unsigned WIDE_W = 54;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_GRID_COLS  = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS  = 2'd1;
  localparam logic [1:0] REG_HEIGHT_DIV = 2'd2;

  localparam logic [8:0] GRID_COLS_RST  = 9'd256;
  localparam logic [8:0] GRID_ROWS_RST  = 9'd256;
  localparam logic [7:0] HEIGHT_DIV_RST = 8'd15;

  typedef struct packed {
    logic       operation;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] height;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_row;
    logic [7:0]         out_col;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               in_range;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_READ,
    ST_SUM,
    ST_SQUARE,
    ST_LEN,
    ST_INIT,
    ST_NORM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       latch;
    logic       addr_load;
    logic [2:0] addr_idx;
    logic       mem_we;
    logic       cap_en;
    logic [2:0] cap_idx;
    logic       sum_en;
    logic       sq_en;
    logic       len_en;
    logic       norm_init;
    logic       norm_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic in_grid;
  } status_t;

endpackage

// ----- rtl/hvn_lane.sv -----
// ----------------------------------------------------------------------------
// hvn_lane
// Bit-serial normalizer: one component scaled to Q1.14 by exact root search.
// ----------------------------------------------------------------------------
module hvn_lane
  import hvn_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    init_i,
  input  logic                    step_i,
  input  logic [LEN_W-1:0]        len_i,
  input  logic [SQ_W-1:0]         msq_i,
  input  logic                    neg_i,
  output logic signed [15:0]      value_o
);

  logic [WIDE_W-1:0] acc_q, acc_d;
  logic [WIDE_W-1:0] inc_q, inc_d;
  logic [WIDE_W-1:0] rem_q, rem_d;
  logic [15:0]       root_q, root_d;
  logic [15:0]       bit_q, bit_d;
  logic              neg_q, neg_d;
  logic [WIDE_W-1:0] trial;
  logic              take;
  logic [16:0]       rnd;
  logic [15:0]       mag;

  always_comb begin
    trial  = acc_q + inc_q;
    take   = (trial <= rem_q);
    acc_d  = acc_q;
    inc_d  = inc_q;
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    neg_d  = neg_q;
    if (init_i) begin
      acc_d  = '0;
      inc_d  = {{(WIDE_W-LEN_W-30){1'b0}}, len_i, 30'b0};
      rem_d  = {{(WIDE_W-SQ_W-30){1'b0}}, msq_i, 30'b0};
      root_d = '0;
      bit_d  = 16'h8000;
      neg_d  = neg_i;
    end else if (step_i) begin
      acc_d  = (acc_q >> 1) + (take ? inc_q : '0);
      inc_d  = inc_q >> 2;
      rem_d  = take ? rem_q - trial : rem_q;
      root_d = take ? (root_q | bit_q) : root_q;
      bit_d  = bit_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    inc_q  <= inc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    neg_q  <= neg_d;
  end

  assign rnd     = {1'b0, root_q} + 17'd1;
  assign mag     = rnd[16:1];
  assign value_o = neg_q ? -$signed(mag) : $signed(mag);

`ifndef ASSERT_OFF
  a_rem_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !init_i) |=> (rem_q <= $past(rem_q)))
    else $error("remainder grew during root search");
`endif

endmodule

// ----- rtl/hvn_datapath.sv -----
// ----------------------------------------------------------------------------
// hvn_datapath
// Height store, neighbor fetch, face normal sum, squares and normalizers.
// ----------------------------------------------------------------------------
module hvn_datapath
  import hvn_pkg::*;
#(
  parameter int unsigned MAX_COLS = MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  input  in_item_t  in_data_i,
  input  logic [8:0] grid_cols_i,
  input  logic [8:0] grid_rows_i,
  input  logic [7:0] height_div_i,
  output out_item_t out_data_o
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned PW    = 9 + CW;

  logic [7:0]    mem_q [DEPTH];
  logic [AW-1:0] addr_q, addr_d;
  logic [7:0]    rdata_q;
  logic [7:0]    h_q [SAMPLES];

  in_item_t      item_q;
  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;
  logic [7:0]    div_eff;
  logic          in_grid;

  logic [8:0]    rr, cc;
  logic [PW-1:0] prod;

  logic          up, left, down, right;
  logic [3:0]    fv;
  logic signed [SUM_W-1:0] dx [4];
  logic signed [SUM_W-1:0] dz [4];
  logic signed [SUM_W-1:0] sx_d, sz_d, sx_q, sz_q;
  logic [2:0]    cnt;
  logic [10:0]   sy_full;
  logic [SY_W-1:0] sy_q;

  logic signed [2*SUM_W-1:0] px, pz;
  logic [2*SY_W-1:0]         py;
  logic [SQ_W-1:0] sqx_q, sqy_q, sqz_q;
  logic [LEN_W-1:0] len_q;

  logic signed [15:0] nx, ny, nz;
  out_item_t out_q;

  always_comb begin
    if (32'(grid_cols_i) < 32'd2) begin
      cols_eff = CW'(2);
    end else if (32'(grid_cols_i) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(grid_cols_i);
    end
    if (32'(grid_rows_i) < 32'd2) begin
      rows_eff = RW'(2);
    end else if (32'(grid_rows_i) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(grid_rows_i);
    end
    div_eff = (height_div_i == 8'd0) ? 8'd1 : height_div_i;
  end

  assign in_grid = (32'(item_q.row) < 32'(rows_eff)) && (32'(item_q.col) < 32'(cols_eff));
  assign status_o.op      = item_q.operation;
  assign status_o.in_grid = in_grid;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
    end
  end

  always_comb begin
    case (cmd_i.addr_idx)
      3'd0, 3'd1, 3'd2: rr = {1'b0, item_q.row} - 9'd1;
      3'd6, 3'd7:       rr = {1'b0, item_q.row} + 9'd1;
      default:          rr = {1'b0, item_q.row};
    endcase
    case (cmd_i.addr_idx)
      3'd0, 3'd3, 3'd6: cc = {1'b0, item_q.col} - 9'd1;
      3'd2, 3'd5:       cc = {1'b0, item_q.col} + 9'd1;
      default:          cc = {1'b0, item_q.col};
    endcase
    prod   = PW'(rr) * PW'(cols_eff);
    addr_d = AW'(prod + PW'(cc));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_load) begin
      addr_q <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we && in_grid) begin
      mem_q[addr_q] <= item_q.height;
    end
    rdata_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      h_q[cmd_i.cap_idx] <= rdata_q;
    end
  end

  always_comb begin
    up    = (item_q.row != 8'd0);
    left  = (item_q.col != 8'd0);
    down  = (32'(item_q.row) + 32'd1 < 32'(rows_eff));
    right = (32'(item_q.col) + 32'd1 < 32'(cols_eff));
    fv    = {down & right, down & left, up & right, up & left};
    dx[0] = $signed({3'b0, h_q[0]}) - $signed({3'b0, h_q[1]});
    dz[0] = $signed({3'b0, h_q[0]}) - $signed({3'b0, h_q[3]});
    dx[1] = $signed({3'b0, h_q[1]}) - $signed({3'b0, h_q[2]});
    dz[1] = $signed({3'b0, h_q[1]}) - $signed({3'b0, h_q[4]});
    dx[2] = $signed({3'b0, h_q[3]}) - $signed({3'b0, h_q[4]});
    dz[2] = $signed({3'b0, h_q[3]}) - $signed({3'b0, h_q[6]});
    dx[3] = $signed({3'b0, h_q[4]}) - $signed({3'b0, h_q[5]});
    dz[3] = $signed({3'b0, h_q[4]}) - $signed({3'b0, h_q[7]});
    sx_d  = '0;
    sz_d  = '0;
    for (int i = 0; i < 4; i++) begin
      if (fv[i]) begin
        sx_d = sx_d + dx[i];
        sz_d = sz_d + dz[i];
      end
    end
    cnt     = 3'($countones(fv));
    sy_full = 11'(cnt) * 11'(div_eff);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      sx_q <= sx_d;
      sz_q <= sz_d;
      sy_q <= sy_full[SY_W-1:0];
    end
  end

  assign px = sx_q * sx_q;
  assign pz = sz_q * sz_q;
  assign py = sy_q * sy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sqx_q <= px[SQ_W-1:0];
      sqy_q <= py[SQ_W-1:0];
      sqz_q <= pz[SQ_W-1:0];
    end
    if (cmd_i.len_en) begin
      len_q <= LEN_W'(sqx_q) + LEN_W'(sqy_q) + LEN_W'(sqz_q);
    end
  end

  hvn_lane u_lane_x (
    .clk_i, .rst_ni,
    .init_i(cmd_i.norm_init), .step_i(cmd_i.norm_step),
    .len_i(len_q), .msq_i(sqx_q), .neg_i(sx_q[SUM_W-1]), .value_o(nx)
  );

  hvn_lane u_lane_y (
    .clk_i, .rst_ni,
    .init_i(cmd_i.norm_init), .step_i(cmd_i.norm_step),
    .len_i(len_q), .msq_i(sqy_q), .neg_i(1'b0), .value_o(ny)
  );

  hvn_lane u_lane_z (
    .clk_i, .rst_ni,
    .init_i(cmd_i.norm_init), .step_i(cmd_i.norm_step),
    .len_i(len_q), .msq_i(sqz_q), .neg_i(sz_q[SUM_W-1]), .value_o(nz)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_row  <= item_q.row;
      out_q.out_col  <= item_q.col;
      out_q.normal_x <= in_grid ? nx : 16'sd0;
      out_q.normal_y <= in_grid ? ny : 16'sd0;
      out_q.normal_z <= in_grid ? nz : 16'sd0;
      out_q.in_range <= in_grid;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/hvn_ctrl.sv -----
// ----------------------------------------------------------------------------
// hvn_ctrl
// Sequencer: accept, decode, write or fetch neighbors, sum, square, normalize, transfer out.
// ----------------------------------------------------------------------------
module hvn_ctrl
  import hvn_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       in_xfer;
  logic       out_free;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        cnt_d = '0;
        if (status_i.op == OP_WRITE) begin
          state_d = ST_WRITE;
        end else if (status_i.in_grid) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_READ: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(SAMPLES + 1)) state_d = ST_SUM;
      end
      ST_SUM:    state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_LEN;
      ST_LEN:    state_d = ST_INIT;
      ST_INIT: begin
        cnt_d   = '0;
        state_d = ST_NORM;
      end
      ST_NORM: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(NORM_STEPS - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.addr_load = 1'b1;
        cmd_o.addr_idx  = 3'd4;
      end
      ST_WRITE: cmd_o.mem_we = 1'b1;
      ST_READ: begin
        cmd_o.addr_load = (cnt_q < 4'(SAMPLES));
        cmd_o.addr_idx  = cnt_q[2:0];
        cmd_o.cap_en    = (cnt_q >= 4'd2);
        cmd_o.cap_idx   = 3'(cnt_q - 4'd2);
      end
      ST_SUM:    cmd_o.sum_en    = 1'b1;
      ST_SQUARE: cmd_o.sq_en     = 1'b1;
      ST_LEN:    cmd_o.len_en    = 1'b1;
      ST_INIT:   cmd_o.norm_init = 1'b1;
      ST_NORM:   cmd_o.norm_step = 1'b1;
      ST_OUT:    cmd_o.out_load  = out_free;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_DECODE))
    else $error("accepted transfer did not move to decode");
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output state");
  a_norm_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NORM && cnt_q == 4'(NORM_STEPS - 1)) |=> (state_q == ST_OUT))
    else $error("normalizer ran past its step count");
`endif

endmodule

// ----- rtl/heightfield_vertex_normals_top.sv -----
// ----------------------------------------------------------------------------
// heightfield_vertex_normals_top
// Height grid store with vertex normal queries and an APB register port.
// ----------------------------------------------------------------------------
// A write item passes decode and the store write before the next item is
// accepted. A query inside the grid is decoded, fetches eight neighbor
// samples through the single store port, sums faces, squares, forms the
// length, loads the root search, runs the bit-serial root search (one
// result bit per cycle, three components in parallel) and loads the output
// register. A query outside the grid goes from decode to the output state.
// A new result waits there while the last result is stalled at the output.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted. The store is not cleared:
// query only samples that were written.
module heightfield_vertex_normals_top
  import hvn_pkg::*;
#(
  parameter int unsigned MAX_COLS = MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0] grid_cols_q;
  logic [8:0] grid_rows_q;
  logic [7:0] height_div_q;
  logic       cfg_we;
  cmd_t       cmd;
  status_t    status;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q  <= GRID_COLS_RST;
      grid_rows_q  <= GRID_ROWS_RST;
      height_div_q <= HEIGHT_DIV_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_GRID_COLS:  grid_cols_q  <= pwdata[8:0];
        REG_GRID_ROWS:  grid_rows_q  <= pwdata[8:0];
        REG_HEIGHT_DIV: height_div_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GRID_COLS:  prdata = {23'b0, grid_cols_q};
      REG_GRID_ROWS:  prdata = {23'b0, grid_rows_q};
      REG_HEIGHT_DIV: prdata = {24'b0, height_div_q};
      default:        prdata = '0;
    endcase
  end

  hvn_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .status_i(status),
    .cmd_o(cmd)
  );

  hvn_datapath #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i(cmd),
    .status_o(status),
    .in_data_i,
    .grid_cols_i(grid_cols_q),
    .grid_rows_i(grid_rows_q),
    .height_div_i(height_div_q),
    .out_data_o
  );

endmodule

// ----- tb/sv/hvn_normal_checker.sv -----
// ----------------------------------------------------------------------------
// hvn_normal_checker
// Watches the item and result channels and the register port of the
// height-field vertex normal unit. It keeps its own copy of the height grid
// and the grid settings, works out the unit normal for every accepted query,
// and compares each accepted result with the oldest one still expected.
// ----------------------------------------------------------------------------
module hvn_normal_checker
  import hvn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  logic [7:0]  sample_mem [0:65535];
  logic [8:0]  cols_reg;
  logic [8:0]  rows_reg;
  logic [7:0]  div_reg;
  out_item_t   normal_q [$];
  int          fail_count;
  int          checked;

  assign fail_count_o = fail_count;
  assign pending_o    = normal_q.size();
  assign checked_o    = checked;

  function automatic int unsigned clamp_dim(logic [8:0] v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic void add_face(int unsigned i, int unsigned j, int unsigned cols,
                                   inout int sx, inout int sz);
    int h0;
    h0 = sample_mem[i * cols + j];
    sx += h0 - int'(sample_mem[i * cols + j + 1]);
    sz += h0 - int'(sample_mem[(i + 1) * cols + j]);
  endfunction

  // round(16384 * s / sqrt(len2)), ties away from zero, by bisection on odd k
  function automatic int unit_q14(int s, longint unsigned len2);
    longint unsigned mag, t, target, k;
    int unsigned lo, hi, mid;
    mag = (s < 0) ? -s : s;
    t = 64'd32768 * mag;
    target = t * t;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k = 2 * longint'(mid) - 1;
      if (k * k * len2 <= target) lo = mid;
      else hi = mid - 1;
    end
    return (s < 0) ? -int'(lo) : int'(lo);
  endfunction

  function automatic out_item_t predict_normal(in_item_t it);
    out_item_t       o;
    int unsigned     cols, rows, dv, r, c, cnt;
    int              sx, sy, sz;
    longint unsigned len2;
    cols = clamp_dim(cols_reg);
    rows = clamp_dim(rows_reg);
    dv = (div_reg == 0) ? 1 : div_reg;
    r = it.row;
    c = it.col;
    o = '0;
    o.out_row = it.row;
    o.out_col = it.col;
    if (r < rows && c < cols) begin
      sx = 0;
      sz = 0;
      cnt = 0;
      if (r >= 1 && c >= 1) begin
        add_face(r - 1, c - 1, cols, sx, sz);
        cnt++;
      end
      if (r >= 1 && c + 1 < cols) begin
        add_face(r - 1, c, cols, sx, sz);
        cnt++;
      end
      if (r + 1 < rows && c >= 1) begin
        add_face(r, c - 1, cols, sx, sz);
        cnt++;
      end
      if (r + 1 < rows && c + 1 < cols) begin
        add_face(r, c, cols, sx, sz);
        cnt++;
      end
      sy = cnt * dv;
      len2 = longint'(sx) * sx + longint'(sy) * sy + longint'(sz) * sz;
      o.in_range = 1'b1;
      if (len2 != 0) begin
        o.normal_x = 16'(unit_q14(sx, len2));
        o.normal_y = 16'(unit_q14(sy, len2));
        o.normal_z = 16'(unit_q14(sz, len2));
      end
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t   exp_item;
    int unsigned cols, rows;
    if (!rst_ni) begin
      cols_reg = GRID_COLS_RST;
      rows_reg = GRID_ROWS_RST;
      div_reg = HEIGHT_DIV_RST;
      normal_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_GRID_COLS:  cols_reg = pwdata_i[8:0];
          REG_GRID_ROWS:  rows_reg = pwdata_i[8:0];
          REG_HEIGHT_DIV: div_reg = pwdata_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (normal_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transfer: %p", out_data_i);
        end else begin
          exp_item = normal_q.pop_front();
          if (out_data_i.out_row !== exp_item.out_row ||
              out_data_i.out_col !== exp_item.out_col ||
              out_data_i.normal_x !== exp_item.normal_x ||
              out_data_i.normal_y !== exp_item.normal_y ||
              out_data_i.normal_z !== exp_item.normal_z ||
              out_data_i.in_range !== exp_item.in_range) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected %p, got %p", exp_item, out_data_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.operation == OP_QUERY) begin
          normal_q.push_back(predict_normal(in_data_i));
        end else begin
          cols = clamp_dim(cols_reg);
          rows = clamp_dim(rows_reg);
          if (in_data_i.row < rows && in_data_i.col < cols)
            sample_mem[in_data_i.row * cols + in_data_i.col] = in_data_i.height;
        end
      end
    end
  end

endmodule

// ----- tb/sv/heightfield_vertex_normals_top_tb.sv -----
// ----------------------------------------------------------------------------
// heightfield_vertex_normals_top_tb
// Drives grid writes and normal queries into the vertex normal unit over
// several grid settings written through the register port. Each phase fills
// the grid corners, queries the corners and points outside the grid, then
// runs a random mix of writes and queries with random gaps on both sides
// outside the calm phases. Only vertices whose neighbor samples were written are queried.
// ----------------------------------------------------------------------------
module heightfield_vertex_normals_top_tb;
  import hvn_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int NUM_PHASES = 8;
  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count, pending, checked;
  int          cycles = 0;
  int          items_sent = 0;
  bit          calm = 1'b0;
  bit          written [0:65535];
  int unsigned grid_c = 256;
  int unsigned grid_r = 256;

  heightfield_vertex_normals_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  hvn_normal_checker normal_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("heightfield_vertex_normals_top: mismatch");
      $finish;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // result side: stall a random number of cycles before each transfer
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic bit cell_ready(int unsigned i, int unsigned j);
    return written[i * grid_c + j] && written[i * grid_c + j + 1] &&
           written[(i + 1) * grid_c + j];
  endfunction

  function automatic bit query_safe(int unsigned r, int unsigned c);
    if (r >= grid_r || c >= grid_c) return 1'b1;
    if (r >= 1 && c >= 1 && !cell_ready(r - 1, c - 1)) return 1'b0;
    if (r >= 1 && c + 1 < grid_c && !cell_ready(r - 1, c)) return 1'b0;
    if (r + 1 < grid_r && c >= 1 && !cell_ready(r, c - 1)) return 1'b0;
    if (r + 1 < grid_r && c + 1 < grid_c && !cell_ready(r, c)) return 1'b0;
    return 1'b1;
  endfunction

  // a point among the five nearest either end of a dimension
  function automatic int unsigned corner_pick(int unsigned n);
    int unsigned v;
    v = $urandom_range(0, (n < 5 ? n : 5) - 1);
    return $urandom_range(0, 1) ? n - 1 - v : v;
  endfunction

  task automatic send_item(logic op, int unsigned r, int unsigned c, int unsigned h);
    int gap;
    in_item_t it;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.operation = op;
    it.row = 8'(r);
    it.col = 8'(c);
    it.height = 8'(h);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (op == OP_WRITE && r < grid_r && c < grid_c) written[r * grid_c + c] = 1'b1;
  endtask

  task automatic send_query(int unsigned r, int unsigned c);
    if (query_safe(r, c)) send_item(OP_QUERY, r, c, $urandom_range(0, 255));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned set_cols [NUM_PHASES] = '{256, 2, 0, 5, 16, 511, 9, 300};
    int unsigned set_rows [NUM_PHASES] = '{256, 2, 511, 7, 3, 2, 9, 256};
    int unsigned set_div  [NUM_PHASES] = '{15, 1, 0, 37, 200, 255, 128, 15};
    int unsigned s_r, s_c, r, c, sel;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_reg(REG_GRID_COLS, set_cols[p]);
        write_reg(REG_GRID_ROWS, set_rows[p]);
        write_reg(REG_HEIGHT_DIV, set_div[p]);
      end
      grid_c = clamp_dim(set_cols[p]);
      grid_r = clamp_dim(set_rows[p]);
      calm = (p == 4 || p == 6);
      s_r = grid_r < 5 ? grid_r : 5;
      s_c = grid_c < 5 ? grid_c : 5;
      for (int a = 0; a < s_r; a++)
        for (int b = 0; b < s_c; b++)
          for (int q = 0; q < 4; q++) begin
            r = q[0] ? grid_r - 1 - a : a;
            c = q[1] ? grid_c - 1 - b : b;
            send_item(OP_WRITE, r, c,
                      p == 0 ? (((r + c) & 1) ? 255 : 0) : $urandom_range(0, 255));
          end
      send_query(0, 0);
      send_query(0, grid_c - 1);
      send_query(grid_r - 1, 0);
      send_query(grid_r - 1, grid_c - 1);
      send_query(1, 1);
      send_query(255, 255);
      send_query(grid_r < 256 ? grid_r : 0, grid_c < 256 ? grid_c : 0);
      send_item(OP_WRITE, 255, 255, 8'hA5);
      for (int k = 0; k < 155; k++) begin
        if (p == 3 && k == 65) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          send_item(OP_WRITE, corner_pick(grid_r), corner_pick(grid_c), $urandom_range(0, 255));
        end else if (sel < 80) begin
          r = corner_pick(grid_r);
          c = corner_pick(grid_c);
          if (query_safe(r, c)) send_query(r, c);
          else send_query(0, 0);
        end else if (sel < 92) begin
          if (grid_c < 256) send_query($urandom_range(0, 255), $urandom_range(grid_c, 255));
          else if (grid_r < 256) send_query($urandom_range(grid_r, 255), $urandom_range(0, 255));
          else send_query(corner_pick(grid_r), corner_pick(grid_c));
        end else begin
          send_item(OP_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
        end
      end
    end
    drain();
    $display("ran %0d grid settings, %0d items sent, %0d results checked",
             NUM_PHASES, items_sent, checked);
    if (fail_count == 0) begin
      $display("heightfield_vertex_normals_top: match");
    end else begin
      $display("heightfield_vertex_normals_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hvn_pkg.sv
rtl/hvn_lane.sv
rtl/hvn_datapath.sv
rtl/hvn_ctrl.sv
rtl/heightfield_vertex_normals_top.sv
tb/sv/hvn_normal_checker.sv
tb/sv/heightfield_vertex_normals_top_tb.sv
